// ===== design/scia_pkg.sv =====
// ----------------------------------------------------------------------------
// scia_pkg
// Shared types and codes of the sampled curve interpolation and average core.
// ----------------------------------------------------------------------------
package scia_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_POINT = 2'd2,
		OP_RANGE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_ORDER     = 3'd2,
		ST_ZERO_SPAN = 3'd3,
		ST_TOO_FEW   = 3'd4
	} status_t;

	localparam logic [0:0] REG_REDSHIFT = 1'b0;
	localparam logic [0:0] REG_GAIN     = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] freq_low;
		logic [31:0] freq_high;
		logic [15:0] transmission;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  status;
	} out_item_t;

endpackage

// ===== design/sampled_curve_interp_and_average_core.sv =====
// ----------------------------------------------------------------------------
// sampled_curve_interp_and_average_core
// Sample table with point interpolation and trapezoid range average.
// ----------------------------------------------------------------------------
// Each start gives exactly one result; the receiver cannot stall it. A point
// query walks the table from entry zero, one sample a cycle through the one
// read port of the sample memory, then runs a bit-serial divide. A range
// query walks the table twice, once for each end, doing two interpolations
// (each with a divide unless that end is padded) and one final divide. The
// memory read port and the serial divider set the rate.
module sampled_curve_interp_and_average_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  scia_pkg::in_item_t   item,
	output logic                 result_valid,
	output scia_pkg::out_item_t  result,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_data
);
	import scia_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD_RD, S_LOAD_CHK, S_ENDS_RD, S_ENDS_WAIT, S_SCAN,
		S_INTERP, S_DIV_WAIT, S_ACC, S_FINAL_DIV, S_GAIN, S_DONE
	} state_t;

	logic [31:0] mem_f [TABLE_DEPTH];
	logic [15:0] mem_t [TABLE_DEPTH];

	logic [23:0] redshift_q;
	logic [31:0] gain_q;
	logic [CW-1:0] count_q;

	state_t        state_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0]   rd_f_q;
	logic [15:0]   rd_t_q;

	in_item_t      it_q;
	logic [1:0]    op_q;
	logic [39:0]   a_q, b_q;
	logic [31:0]   first_f_q, last_f_q;
	logic [15:0]   first_t_q, last_t_q;
	logic [CW-1:0] idx_q;
	logic          rd_ok_q;
	// Interpolation phase: 0 = point / range start, 1 = range end.
	logic          phase_q;
	logic [39:0]   px_q;
	logic [16:0]   py_q;
	logic [31:0]   lf_q, rf_q;
	logic [15:0]   lt_q, rt_q;
	logic          bin_q;
	logic [16:0]   ya_q, yb_q;
	logic [127:0]  acc_q;
	logic [63:0]   avg_q;
	logic [63:0]   mul_q;
	logic          mul_stage_q;
	logic          tl_up_q;

	// Divider
	logic          div_go;
	logic [127:0]  div_num;
	logic [63:0]   div_den;
	logic          div_done;
	logic [63:0]   div_quo;

	scia_div #(.NUM_BITS(128), .DEN_BITS(64), .QUO_BITS(64)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	function automatic logic [39:0] frame(input logic [31:0] nu, input logic [23:0] rs);
		logic [55:0] hi;
		logic [39:0] lo;
		begin
			hi = 56'(nu[31:16]) * 56'(rs);
			lo = 40'(nu[15:0]) * 40'(rs);
			frame = hi[39:0] + 40'(lo[39:16]);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_f[mem_wa] <= it_q.freq_low;
			mem_t[mem_wa] <= it_q.transmission;
		end
		rd_f_q <= mem_f[mem_ra];
		rd_t_q <= mem_t[mem_ra];
	end

	assign busy = (state_q != S_IDLE);

	// Interpolation bracket decision for the current phase target.
	logic [39:0] tgt;
	logic [39:0] rf_x;
	assign tgt  = phase_q ? b_q : a_q;
	assign rf_x = 40'(rd_f_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			redshift_q   <= 24'd65536;
			gain_q       <= 32'd65536;
			result_valid <= 1'b0;
			result       <= '0;
			mem_we       <= 1'b0;
			mem_wa       <= '0;
			mem_ra       <= '0;
			div_go       <= 1'b0;
			div_num      <= '0;
			div_den      <= '0;
		end else begin
			result_valid <= 1'b0;
			mem_we       <= 1'b0;
			div_go       <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == REG_REDSHIFT)
					redshift_q <= cfg_data[23:0];
				else
					gain_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						it_q  <= item;
						op_q  <= item.operation;
						a_q   <= frame(item.freq_low, redshift_q);
						b_q   <= frame(item.freq_high, redshift_q);
						unique case (op_t'(item.operation))
							OP_CLEAR: begin
								count_q <= '0;
								result  <= '{value: '0, status: ST_OK};
								state_q <= S_DONE;
							end
							OP_LOAD: begin
								mem_ra  <= AW'(count_q - 1'b1);
								state_q <= S_LOAD_RD;
							end
							default: begin
								if (count_q < CW'(2)) begin
									result  <= '{value: '0, status: ST_TOO_FEW};
									state_q <= S_DONE;
								end else begin
									mem_ra  <= '0;
									state_q <= S_ENDS_RD;
								end
							end
						endcase
					end
				end
				S_LOAD_RD: state_q <= S_LOAD_CHK;
				S_LOAD_CHK: begin
					if (count_q == CW'(TABLE_DEPTH))
						result <= '{value: '0, status: ST_FULL};
					else if (count_q != '0 && it_q.freq_low <= rd_f_q)
						result <= '{value: '0, status: ST_ORDER};
					else begin
						result  <= '{value: '0, status: ST_OK};
						mem_we  <= 1'b1;
						mem_wa  <= AW'(count_q);
						count_q <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_ENDS_RD: begin
					// Entry zero is read now; fetch the last entry next.
					mem_ra  <= AW'(count_q - 1'b1);
					state_q <= S_ENDS_WAIT;
					idx_q   <= '0;
				end
				S_ENDS_WAIT: begin
					if (idx_q == '0) begin
						first_f_q <= rd_f_q;
						first_t_q <= rd_t_q;
						idx_q     <= CW'(1);
					end else begin
						last_f_q <= rd_f_q;
						last_t_q <= rd_t_q;
						if (op_q == OP_RANGE && a_q > b_q) begin
							a_q <= b_q;
							b_q <= a_q;
						end
						if (op_q == OP_POINT) begin
							if (a_q < 40'(first_f_q) || a_q > 40'(rd_f_q)) begin
								result  <= '{value: '0, status: ST_OK};
								state_q <= S_DONE;
							end else begin
								phase_q <= 1'b0;
								state_q <= S_SCAN;
							end
						end else if (a_q == b_q) begin
							result  <= '{value: '0, status: ST_ZERO_SPAN};
							state_q <= S_DONE;
						end else if (((a_q < b_q) ? a_q : b_q) > 40'(rd_f_q) ||
								((a_q < b_q) ? b_q : a_q) < 40'(first_f_q)) begin
							result  <= '{value: '0, status: ST_OK};
							state_q <= S_DONE;
						end else begin
							phase_q <= 1'b0;
							state_q <= S_SCAN;
						end
						idx_q       <= '0;
						mem_ra      <= '0;
						rd_ok_q     <= 1'b0;
						acc_q       <= '0;
					end
				end
				S_SCAN: begin
					// Walk entries; rd_* holds entry idx_q-1 when rd_ok_q.
					if (!rd_ok_q) begin
						mem_ra  <= AW'(1);
						idx_q   <= CW'(1);
						rd_ok_q <= 1'b1;
					end else begin
						if (phase_q && rf_x > a_q && rf_x <= b_q) begin
							// Trapezoid segment from the previous point.
							acc_q <= acc_q + 128'((px_q == a_q ? 64'(ya_q) : 64'(py_q))
								+ 64'(rd_t_q)) * 128'(rf_x - px_q);
							px_q  <= rf_x;
							py_q  <= 17'(rd_t_q);
						end
						if (rf_x <= tgt) begin
							lf_q <= rd_f_q;
							lt_q <= rd_t_q;
							bin_q <= 1'b1;
						end else if (bin_q) begin
							rf_q  <= rd_f_q;
							rt_q  <= rd_t_q;
							bin_q <= 1'b0;
						end
						if (idx_q == count_q) begin
							state_q <= S_INTERP;
						end else begin
							mem_ra <= AW'(idx_q + 1'b1);
							idx_q  <= idx_q + 1'b1;
						end
					end
				end
				S_INTERP: begin
					// Curve value at tgt, padded past both ends.
					if (tgt < 40'(first_f_q)) begin
						if (phase_q) yb_q <= 17'(first_t_q >> 1); else ya_q <= 17'(first_t_q >> 1);
						state_q <= S_ACC;
					end else if (tgt >= 40'(last_f_q)) begin
						if (phase_q)
							yb_q <= (tgt == 40'(last_f_q)) ? 17'(last_t_q) : 17'(last_t_q >> 1);
						else
							ya_q <= (tgt == 40'(last_f_q)) ? 17'(last_t_q) : 17'(last_t_q >> 1);
						state_q <= S_ACC;
					end else begin
						tl_up_q <= rt_q >= lt_q;
						div_num <= 128'(tgt - 40'(lf_q)) *
							128'((rt_q >= lt_q) ? rt_q - lt_q : lt_q - rt_q);
						div_den <= 64'(rf_q - lf_q);
						div_go  <= 1'b1;
						state_q <= S_DIV_WAIT;
					end
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						if (phase_q)
							yb_q <= tl_up_q ? 17'(lt_q) + 17'(div_quo) : 17'(lt_q) - 17'(div_quo);
						else
							ya_q <= tl_up_q ? 17'(lt_q) + 17'(div_quo) : 17'(lt_q) - 17'(div_quo);
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (op_q == OP_POINT) begin
						avg_q       <= 64'(ya_q);
						mul_stage_q <= 1'b0;
						state_q     <= S_GAIN;
					end else if (!phase_q) begin
						// Second pass: walk bins from a to b, then interpolate b.
						phase_q <= 1'b1;
						px_q    <= a_q;
						py_q    <= ya_q;
						rd_ok_q <= 1'b0;
						bin_q   <= 1'b0;
						idx_q   <= '0;
						mem_ra  <= '0;
						state_q <= S_SCAN;
					end else begin
						div_num <= acc_q + 128'(64'(py_q) + 64'(yb_q)) * 128'(b_q - px_q);
						div_den <= 64'(b_q - a_q) << 1;
						div_go  <= 1'b1;
						state_q <= S_FINAL_DIV;
					end
				end
				S_FINAL_DIV: begin
					if (div_done) begin
						avg_q       <= div_quo;
						mul_stage_q <= 1'b0;
						state_q     <= S_GAIN;
					end
				end
				S_GAIN: begin
					// One 32x32 product of the low average half and the gain, then a saturating check.
					if (!mul_stage_q) begin
						mul_q       <= 64'(avg_q[31:0]) * 64'(gain_q);
						mul_stage_q <= 1'b1;
					end else begin
						if (avg_q[63:32] != '0 && gain_q != '0)
							result <= '{value: '1, status: ST_OK};
						else if (mul_q[63:48] != '0)
							result <= '{value: '1, status: ST_OK};
						else
							result <= '{value: mul_q[47:16], status: ST_OK};
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					result_valid <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("sample count beyond table depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
	// The count steps at the same edge that raises the write enable.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> count_q == $past(count_q) + 1'b1)
		else $error("table write without count step");
endmodule

// ===== design/scia_div.sv =====
// ----------------------------------------------------------------------------
// scia_div
// Restoring divider, one quotient bit per cycle, quotient saturating to all
// ones when it does not fit or the divisor is zero.
// ----------------------------------------------------------------------------
module scia_div #(
	parameter int NUM_BITS = 128,
	parameter int DEN_BITS = 64,
	parameter int QUO_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [QUO_BITS-1:0] quo
);
	localparam int CW = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [CW-1:0]       cnt_q;
	logic                run_q;
	logic                ovf_q;
	logic [DEN_BITS:0]   shifted;
	logic                fits;

	assign shifted = {rem_q, num_q[NUM_BITS-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NUM_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= (den == '0);
		end else if (run_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
			// The remainder stays below the divisor, so it fits in DEN_BITS bits.
			rem_q <= fits ? DEN_BITS'(shifted - {1'b0, den_q}) : shifted[DEN_BITS-1:0];
		end
	end

	always_comb begin
		quo = quo_q[QUO_BITS-1:0];
		if (ovf_q || (quo_q[NUM_BITS-1:QUO_BITS] != '0))
			quo = '1;
	end
endmodule
